// File: rtl/core/lpcp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lpcp_pkg;

    localparam logic [16:0] MAX_DIM     = 17'd4096;
    localparam logic [6:0]  EDGE_MARGIN = 7'd10;
    localparam int          PIX_W       = 12;
    localparam int          CAM_W       = 33;
    localparam int          NORM_W      = 24;
    localparam int          QUO_BITS    = 24;

    typedef enum logic [2:0] {
        REG_ROT_ROW0   = 3'd0,
        REG_ROT_ROW1   = 3'd1,
        REG_ROT_ROW2   = 3'd2,
        REG_TRANS_VEC  = 3'd3,
        REG_INTRINSIC  = 3'd4,
        REG_RADIAL     = 3'd5,
        REG_TANGENTIAL = 3'd6,
        REG_IMAGE_SIZE = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [2:0][2:0][19:0] rot;
        logic [2:0][20:0]      trans;
        logic [15:0]           fx;
        logic [15:0]           fy;
        logic [15:0]           cx;
        logic [15:0]           cy;
        logic [2:0][20:0]      k;
        logic [31:0]           p1;
        logic [31:0]           p2;
        logic [15:0]           img_w;
        logic [15:0]           img_h;
    } t_cfg;

endpackage
`default_nettype wire

// File: rtl/core/lpcp_regs.sv
`timescale 1ns / 1ps
`default_nettype none
module lpcp_regs
    import lpcp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    logic [63:0] r_rot0, r_rot1, r_rot2, r_intr, r_tang;
    logic [62:0] r_trans, r_rad;
    logic [31:0] r_img;
    t_reg_idx    w_idx;
    logic        w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[5:3]);
    assign w_wr   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot0  <= 64'd262144;
            r_rot1  <= 64'd274877906944;
            r_rot2  <= 64'd288230376151711744;
            r_trans <= '0;
            r_intr  <= '0;
            r_rad   <= '0;
            r_tang  <= '0;
            r_img   <= 32'd70780800;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_ROT_ROW0:   r_rot0  <= pwdata;
                REG_ROT_ROW1:   r_rot1  <= pwdata;
                REG_ROT_ROW2:   r_rot2  <= pwdata;
                REG_TRANS_VEC:  r_trans <= pwdata[62:0];
                REG_INTRINSIC:  r_intr  <= pwdata;
                REG_RADIAL:     r_rad   <= pwdata[62:0];
                REG_TANGENTIAL: r_tang  <= pwdata;
                REG_IMAGE_SIZE: r_img   <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_ROT_ROW0:   prdata = r_rot0;
            REG_ROT_ROW1:   prdata = r_rot1;
            REG_ROT_ROW2:   prdata = r_rot2;
            REG_TRANS_VEC:  prdata = {1'b0, r_trans};
            REG_INTRINSIC:  prdata = r_intr;
            REG_RADIAL:     prdata = {1'b0, r_rad};
            REG_TANGENTIAL: prdata = r_tang;
            REG_IMAGE_SIZE: prdata = {32'd0, r_img};
            default:        prdata = '0;
        endcase
    end

    always_comb begin
        o_cfg.rot[0]   = {r_rot0[59:40], r_rot0[39:20], r_rot0[19:0]};
        o_cfg.rot[1]   = {r_rot1[59:40], r_rot1[39:20], r_rot1[19:0]};
        o_cfg.rot[2]   = {r_rot2[59:40], r_rot2[39:20], r_rot2[19:0]};
        o_cfg.trans[0] = r_trans[20:0];
        o_cfg.trans[1] = r_trans[41:21];
        o_cfg.trans[2] = r_trans[62:42];
        o_cfg.fx       = r_intr[15:0];
        o_cfg.fy       = r_intr[31:16];
        o_cfg.cx       = r_intr[47:32];
        o_cfg.cy       = r_intr[63:48];
        o_cfg.k[0]     = r_rad[20:0];
        o_cfg.k[1]     = r_rad[41:21];
        o_cfg.k[2]     = r_rad[62:42];
        o_cfg.p1       = r_tang[31:0];
        o_cfg.p2       = r_tang[63:32];
        o_cfg.img_w    = r_img[15:0];
        o_cfg.img_h    = r_img[31:16];
    end

endmodule
`default_nettype wire

// File: rtl/core/lpcp_xform.sv
`timescale 1ns / 1ps
`default_nettype none
module lpcp_xform
    import lpcp_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_en,
    input  wire logic                    i_valid,
    input  wire logic signed [23:0]      i_x,
    input  wire logic signed [23:0]      i_y,
    input  wire logic signed [23:0]      i_z,
    input  wire t_cfg                    i_cfg,
    output logic                         o_valid,
    output logic                         o_fwd,
    output logic signed [CAM_W-1:0]      o_cam0,
    output logic signed [CAM_W-1:0]      o_cam1,
    output logic signed [CAM_W-1:0]      o_cam2
);

    logic signed [43:0] r_prod [3][3];
    logic signed [43:0] n_prod [3][3];
    logic signed [20:0] r_t [3];
    logic signed [23:0] w_p [3];
    logic               r_v1, r_fwd1, r_v2, r_fwd2;
    logic signed [46:0] w_acc [3];
    logic signed [CAM_W-1:0] r_cam [3];

    assign w_p[0] = i_x;
    assign w_p[1] = i_y;
    assign w_p[2] = i_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_prod[i][j] = $signed(i_cfg.rot[i][j]) * w_p[j];
            end
        end
        for (int i = 0; i < 3; i++) begin
            w_acc[i] = 47'(r_prod[i][0]) + 47'(r_prod[i][1]) + 47'(r_prod[i][2])
                     + (47'(r_t[i]) <<< 18);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
            for (int i = 0; i < 3; i++) r_t[i] <= $signed(i_cfg.trans[i]);
            r_fwd1 <= ~i_x[23] & (i_x != '0);
            r_fwd2 <= r_fwd1;
            for (int i = 0; i < 3; i++) r_cam[i] <= w_acc[i][46:14];
        end
    end

    assign o_valid = r_v2;
    assign o_fwd   = r_fwd2;
    assign o_cam0  = r_cam[0];
    assign o_cam1  = r_cam[1];
    assign o_cam2  = r_cam[2];

endmodule
`default_nettype wire

// File: rtl/core/lpcp_div.sv
`timescale 1ns / 1ps
`default_nettype none
module lpcp_div
    import lpcp_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_en,
    input  wire logic                    i_valid,
    input  wire logic                    i_fwd,
    input  wire logic signed [CAM_W-1:0] i_cam0,
    input  wire logic signed [CAM_W-1:0] i_cam1,
    input  wire logic signed [CAM_W-1:0] i_cam2,
    output logic                         o_valid,
    output logic                         o_ok,
    output logic signed [NORM_W-1:0]     o_xn,
    output logic signed [NORM_W-1:0]     o_yn
);

    logic [QUO_BITS:0]   r_v;
    logic [QUO_BITS:0]   r_ok;
    logic [31:0]         r_den  [QUO_BITS+1];
    logic [3:0]          r_magx [QUO_BITS+1];
    logic [3:0]          r_magy [QUO_BITS+1];
    logic [31:0]         r_remx [QUO_BITS+1];
    logic [31:0]         r_remy [QUO_BITS+1];
    logic [QUO_BITS-1:0] r_qx   [QUO_BITS+1];
    logic [QUO_BITS-1:0] r_qy   [QUO_BITS+1];
    logic                r_ovx  [QUO_BITS+1];
    logic                r_ovy  [QUO_BITS+1];
    logic                r_sx   [QUO_BITS+1];
    logic                r_sy   [QUO_BITS+1];

    logic [32:0] w_mx, w_my;
    logic        w_ovx, w_ovy;

    assign w_mx  = i_cam0[CAM_W-1] ? 33'(-i_cam0) : 33'(i_cam0);
    assign w_my  = i_cam1[CAM_W-1] ? 33'(-i_cam1) : 33'(i_cam1);
    assign w_ovx = {3'd0, w_mx[32:4]} >= i_cam2[31:0];
    assign w_ovy = {3'd0, w_my[32:4]} >= i_cam2[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ok[0]   <= i_fwd & ~i_cam2[CAM_W-1] & (i_cam2 != '0);
            r_den[0]  <= i_cam2[31:0];
            r_magx[0] <= w_mx[3:0];
            r_magy[0] <= w_my[3:0];
            r_remx[0] <= w_ovx ? 32'd0 : {3'd0, w_mx[32:4]};
            r_remy[0] <= w_ovy ? 32'd0 : {3'd0, w_my[32:4]};
            r_qx[0]   <= '0;
            r_qy[0]   <= '0;
            r_ovx[0]  <= w_ovx;
            r_ovy[0]  <= w_ovy;
            r_sx[0]   <= i_cam0[CAM_W-1];
            r_sy[0]   <= i_cam1[CAM_W-1];
        end
    end

    for (genvar k = 1; k <= QUO_BITS; k++) begin : g_stage
        localparam int BIT = QUO_BITS - k;
        logic        w_nbx, w_nby, w_gex, w_gey;
        logic [32:0] w_tx, w_ty;

        if (BIT >= 20) begin : g_bit
            assign w_nbx = r_magx[k-1][BIT-20];
            assign w_nby = r_magy[k-1][BIT-20];
        end else begin : g_zero
            assign w_nbx = 1'b0;
            assign w_nby = 1'b0;
        end

        assign w_tx  = {r_remx[k-1], w_nbx};
        assign w_ty  = {r_remy[k-1], w_nby};
        assign w_gex = w_tx >= {1'b0, r_den[k-1]};
        assign w_gey = w_ty >= {1'b0, r_den[k-1]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ok[k]   <= r_ok[k-1];
                r_den[k]  <= r_den[k-1];
                r_magx[k] <= r_magx[k-1];
                r_magy[k] <= r_magy[k-1];
                r_remx[k] <= w_gex ? 32'(w_tx - {1'b0, r_den[k-1]}) : w_tx[31:0];
                r_remy[k] <= w_gey ? 32'(w_ty - {1'b0, r_den[k-1]}) : w_ty[31:0];
                r_qx[k]   <= {r_qx[k-1][QUO_BITS-2:0], w_gex};
                r_qy[k]   <= {r_qy[k-1][QUO_BITS-2:0], w_gey};
                r_ovx[k]  <= r_ovx[k-1];
                r_ovy[k]  <= r_ovy[k-1];
                r_sx[k]   <= r_sx[k-1];
                r_sy[k]   <= r_sy[k-1];
            end
        end
    end

    localparam logic [QUO_BITS-1:0] QLIM = QUO_BITS'(1) << 22;

    logic [QUO_BITS-1:0]      w_qx, w_qy;
    logic                     r_vo, r_oko;
    logic signed [NORM_W-1:0] r_xn, r_yn;

    assign w_qx = (r_ovx[QUO_BITS] || r_qx[QUO_BITS] > QLIM) ? QLIM : r_qx[QUO_BITS];
    assign w_qy = (r_ovy[QUO_BITS] || r_qy[QUO_BITS] > QLIM) ? QLIM : r_qy[QUO_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (i_en) begin
            r_vo <= r_v[QUO_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_oko <= r_ok[QUO_BITS];
            r_xn  <= r_sx[QUO_BITS] ? -$signed(w_qx) : $signed(w_qx);
            r_yn  <= r_sy[QUO_BITS] ? -$signed(w_qy) : $signed(w_qy);
        end
    end

    assign o_valid = r_vo;
    assign o_ok    = r_oko;
    assign o_xn    = r_xn;
    assign o_yn    = r_yn;

endmodule
`default_nettype wire

// File: rtl/core/lpcp_dist.sv
`timescale 1ns / 1ps
`default_nettype none
module lpcp_dist
    import lpcp_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_en,
    input  wire logic                    i_valid,
    input  wire logic                    i_ok,
    input  wire logic signed [NORM_W-1:0] i_xn,
    input  wire logic signed [NORM_W-1:0] i_yn,
    input  wire t_cfg                    i_cfg,
    output logic                         o_valid,
    output logic [PIX_W-1:0]             o_col,
    output logic [PIX_W-1:0]             o_row,
    output logic                         o_in_view
);

    localparam int NST = 11;

    logic [NST-1:0] r_v;
    logic [NST-1:0] r_ok;
    logic signed [NORM_W-1:0] r_xn [7];
    logic signed [NORM_W-1:0] r_yn [7];

    // square terms
    logic signed [47:0] r1_xx, r1_yy, r1_xy;
    logic signed [25:0] r2_x2, r2_y2, r2_xy;
    logic signed [26:0] r2_r2;
    logic signed [48:0] w2_sum;
    // radial and tangential products
    logic signed [53:0] r3_r4p;
    logic signed [47:0] r3_k1r2;
    logic signed [26:0] r3_r2;
    logic signed [57:0] r3_tx1, r3_ty1;
    logic signed [59:0] r3_tx2, r3_ty2;
    logic signed [27:0] w3_ax, w3_ay;
    logic signed [33:0] w4_r4;
    logic signed [60:0] r4_r6p;
    logic signed [54:0] r4_k2r4;
    logic signed [47:0] r4_k1r2;
    logic signed [51:0] r4_tanx, r4_tany;
    logic signed [60:0] w4_sx, w4_sy;
    logic signed [36:0] w5_r6;
    logic signed [57:0] r5_k3r6;
    logic signed [55:0] r5_rsum;
    logic signed [51:0] r5_tanx, r5_tany;
    logic signed [58:0] w6_rad;
    logic signed [39:0] r6_rad20;
    logic signed [51:0] r6_tanx, r6_tany;
    // coordinate scaling and in-view check
    logic signed [44:0] r7_pxl, r7_pyl;
    logic signed [43:0] r7_pxh, r7_pyh;
    logic signed [51:0] r7_tanx, r7_tany;
    logic signed [63:0] w8_dx, w8_dy;
    logic signed [43:0] r8_xd, r8_yd;
    logic signed [38:0] r9_ful, r9_fvl;
    logic signed [39:0] r9_fuh, r9_fvh;
    logic signed [63:0] w10_su, w10_sv, w10_au, w10_av;
    logic signed [39:0] r10_u, r10_v;
    logic [16:0]        w11_w, w11_h;
    logic signed [39:0] w11_lw, w11_lh;
    logic               w11_in;
    logic [PIX_W-1:0]   r11_col, r11_row;
    logic               r11_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NST-2:0], i_valid};
        end
    end

    always_comb begin
        w2_sum = 49'(r1_xx) + 49'(r1_yy);
        w3_ax  = 28'(r2_r2) + (28'(r2_x2) <<< 1);
        w3_ay  = 28'(r2_r2) + (28'(r2_y2) <<< 1);
        w4_r4  = r3_r4p[53:20];
        w4_sx  = (61'(r3_tx1) <<< 1) + 61'(r3_tx2);
        w4_sy  = (61'(r3_ty1) <<< 1) + 61'(r3_ty2);
        w5_r6  = r4_r6p[56:20];
        w6_rad = (59'sd1 <<< 39) + 59'(r5_rsum) + 59'(r5_k3r6);
        w8_dx  = (64'(r7_pxh) <<< 20) + 64'(r7_pxl) + 64'(r7_tanx);
        w8_dy  = (64'(r7_pyh) <<< 20) + 64'(r7_pyl) + 64'(r7_tany);
        w10_su = (64'(r9_fuh) <<< 21) + 64'(r9_ful) + (64'($signed({1'b0, i_cfg.cx})) <<< 20);
        w10_sv = (64'(r9_fvh) <<< 21) + 64'(r9_fvl) + (64'($signed({1'b0, i_cfg.cy})) <<< 20);
        w10_au = w10_su + (w10_su[63] ? 64'sd16777215 : 64'sd0);
        w10_av = w10_sv + (w10_sv[63] ? 64'sd16777215 : 64'sd0);
        w11_w  = ({1'b0, i_cfg.img_w} > MAX_DIM) ? MAX_DIM : {1'b0, i_cfg.img_w};
        w11_h  = ({1'b0, i_cfg.img_h} > MAX_DIM) ? MAX_DIM : {1'b0, i_cfg.img_h};
        w11_lw = 40'($signed({1'b0, w11_w})) - 40'($signed({1'b0, EDGE_MARGIN}));
        w11_lh = 40'($signed({1'b0, w11_h})) - 40'($signed({1'b0, EDGE_MARGIN}));
        w11_in = r_ok[9]
               && r10_u >= 40'($signed({1'b0, EDGE_MARGIN})) && r10_u < w11_lw
               && r10_v >= 40'($signed({1'b0, EDGE_MARGIN})) && r10_v < w11_lh;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ok <= {r_ok[NST-2:0], i_ok};
            r_xn[0] <= i_xn;
            r_yn[0] <= i_yn;
            for (int i = 1; i < 7; i++) begin
                r_xn[i] <= r_xn[i-1];
                r_yn[i] <= r_yn[i-1];
            end

            r1_xx <= i_xn * i_xn;
            r1_yy <= i_yn * i_yn;
            r1_xy <= i_xn * i_yn;

            r2_x2 <= r1_xx[45:20];
            r2_y2 <= r1_yy[45:20];
            r2_xy <= r1_xy[45:20];
            r2_r2 <= w2_sum[46:20];

            r3_r4p  <= r2_r2 * r2_r2;
            r3_k1r2 <= $signed(i_cfg.k[0]) * r2_r2;
            r3_r2   <= r2_r2;
            r3_tx1  <= $signed(i_cfg.p1) * r2_xy;
            r3_ty1  <= $signed(i_cfg.p2) * r2_xy;
            r3_tx2  <= $signed(i_cfg.p2) * w3_ax;
            r3_ty2  <= $signed(i_cfg.p1) * w3_ay;

            r4_r6p  <= w4_r4 * r3_r2;
            r4_k2r4 <= $signed(i_cfg.k[1]) * w4_r4;
            r4_k1r2 <= r3_k1r2;
            r4_tanx <= w4_sx[60:9];
            r4_tany <= w4_sy[60:9];

            r5_k3r6 <= $signed(i_cfg.k[2]) * w5_r6;
            r5_rsum <= 56'(r4_k1r2) + 56'(r4_k2r4);
            r5_tanx <= r4_tanx;
            r5_tany <= r4_tany;

            r6_rad20 <= w6_rad[58:19];
            r6_tanx  <= r5_tanx;
            r6_tany  <= r5_tany;

            r7_pxl  <= r_xn[5] * $signed({1'b0, r6_rad20[19:0]});
            r7_pyl  <= r_yn[5] * $signed({1'b0, r6_rad20[19:0]});
            r7_pxh  <= r_xn[5] * $signed(r6_rad20[39:20]);
            r7_pyh  <= r_yn[5] * $signed(r6_rad20[39:20]);
            r7_tanx <= r6_tanx;
            r7_tany <= r6_tany;

            r8_xd <= w8_dx[63:20];
            r8_yd <= w8_dy[63:20];

            r9_ful <= $signed({1'b0, i_cfg.fx}) * $signed({1'b0, r8_xd[20:0]});
            r9_fvl <= $signed({1'b0, i_cfg.fy}) * $signed({1'b0, r8_yd[20:0]});
            r9_fuh <= $signed({1'b0, i_cfg.fx}) * $signed(r8_xd[43:21]);
            r9_fvh <= $signed({1'b0, i_cfg.fy}) * $signed(r8_yd[43:21]);

            r10_u <= w10_au[63:24];
            r10_v <= w10_av[63:24];

            r11_in  <= w11_in;
            r11_col <= w11_in ? r10_u[PIX_W-1:0] : '0;
            r11_row <= w11_in ? r10_v[PIX_W-1:0] : '0;
        end
    end

    assign o_valid   = r_v[NST-1];
    assign o_col     = r11_col;
    assign o_row     = r11_row;
    assign o_in_view = r11_in;

endmodule
`default_nettype wire

// File: rtl/core/lidar_point_camera_projection.sv
// LiDAR point to camera pixel projection with lens distortion.
// Input channel: i_valid / o_stall with i_point_x, i_point_y, i_point_z
// (signed, 1/4096 m). A transfer happens when i_valid is high and o_stall low.
// Output channel: o_valid / i_stall with o_pixel_col, o_pixel_row, o_in_view.
// One result leaves for every point, in order.
// Throughput: one point per cycle while the output is not stalled. The path
// from input transfer to o_valid runs through the transform stages, the 24-stage
// restoring divider (one quotient bit a stage) and the distortion multiplier stages.
// Stall: while o_valid is high and i_stall high the whole pipeline holds and
// o_stall is raised; nothing is lost or repeated.
// Reset (synchronous, i_rst_n low) empties the pipeline and loads the
// register defaults: identity rotation, zero translation and coefficients,
// 1920 x 1080 image. Registers sit on an APB port at byte address 8*index;
// write them only while the pipeline is empty.
`timescale 1ns / 1ps
`default_nettype none
module lidar_point_camera_projection
    import lpcp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [5:0]         paddr,
    input  wire logic [63:0]        pwdata,
    output logic [63:0]             prdata,
    output logic                    pready,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [23:0] i_point_x,
    input  wire logic signed [23:0] i_point_y,
    input  wire logic signed [23:0] i_point_z,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [PIX_W-1:0]        o_pixel_col,
    output logic [PIX_W-1:0]        o_pixel_row,
    output logic                    o_in_view
);

    t_cfg w_cfg;
    logic w_en;
    logic w_xv, w_xfwd, w_dv, w_dok;
    logic signed [CAM_W-1:0]  w_c0, w_c1, w_c2;
    logic signed [NORM_W-1:0] w_xn, w_yn;

    assign o_stall = o_valid & i_stall;
    assign w_en    = ~o_stall;

    lpcp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    lpcp_xform u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_x     (i_point_x),
        .i_y     (i_point_y),
        .i_z     (i_point_z),
        .i_cfg   (w_cfg),
        .o_valid (w_xv),
        .o_fwd   (w_xfwd),
        .o_cam0  (w_c0),
        .o_cam1  (w_c1),
        .o_cam2  (w_c2)
    );

    lpcp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_xv),
        .i_fwd   (w_xfwd),
        .i_cam0  (w_c0),
        .i_cam1  (w_c1),
        .i_cam2  (w_c2),
        .o_valid (w_dv),
        .o_ok    (w_dok),
        .o_xn    (w_xn),
        .o_yn    (w_yn)
    );

    lpcp_dist u_dist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (w_dv),
        .i_ok      (w_dok),
        .i_xn      (w_xn),
        .i_yn      (w_yn),
        .i_cfg     (w_cfg),
        .o_valid   (o_valid),
        .o_col     (o_pixel_col),
        .o_row     (o_pixel_row),
        .o_in_view (o_in_view)
    );

endmodule
`default_nettype wire
